>>> rtl/bapr_pkg.sv
package bapr_pkg;

  // Default build values
  localparam int BLOCK_LEN_DEF   = 25;
  localparam int SAMPLE_BITS_DEF = 12;

  // Fixed field widths
  localparam int RANGE_W = 12;
  localparam int AVG_W   = 12;
  localparam int PCT_W   = 20;

  // Divisor width covers both 2*range and the block length
  localparam int DVS_W = RANGE_W + 1;

  localparam logic [RANGE_W-1:0] RANGE_RESET = 12'd953;

  // Saturation limits of the percent field
  localparam logic [PCT_W-1:0] PCT_MAX = {1'b0, {(PCT_W-1){1'b1}}};
  localparam logic [PCT_W-1:0] PCT_MIN = {1'b1, {(PCT_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_AVG,
    ST_PREP,
    ST_LOAD,
    ST_PCT,
    ST_PUSH
  } bapr_state_t;

  typedef struct packed {
    logic start;
    logic clear;
  } acc_ctrl_t;

endpackage

>>> rtl/bapr_if.sv
interface bapr_in_if #(
  parameter int SAMPLE_BITS = bapr_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bapr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bapr_pkg::PCT_W-1:0]   altitude_percent;
  logic        [bapr_pkg::AVG_W-1:0]   block_average;

  modport source (output valid, output altitude_percent, output block_average, input ready);
  modport sink   (input valid, input altitude_percent, input block_average, output ready);
endinterface

>>> rtl/block_average_relative_percent_top.sv
// Block average with reference offset.
// in_ch  : valid/ready stream of unsigned ADC samples, one per transfer.
// out_ch : valid/ready stream of results (altitude_percent, block_average).
// cfg_we/cfg_data : writes range_counts; a value of zero acts as one.
// Samples are summed in blocks of BLOCK_LEN. The first block after reset sets
// the reference average and gives no result; every later block gives one.
// Each sample is added by a bit-serial adder over SUM_W bits
// (SUM_W = SAMPLE_BITS + clog2(BLOCK_LEN)); in_ch.ready is low while it runs.
// At a block end a shared restoring divider, one quotient bit per cycle,
// runs twice (average, then percent) before the result is loaded into the
// output register and the next sample is taken. The reference block only
// runs the average divide.
// The output register holds a result until its transfer; sample intake goes
// on meanwhile and only waits when a new result is ready while the old one
// is still held.
// Synchronous reset clears sums, count and reference and sets range to 953.
module block_average_relative_percent_top #(
  parameter int BLOCK_LEN   = bapr_pkg::BLOCK_LEN_DEF,
  parameter int SAMPLE_BITS = bapr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bapr_pkg::RANGE_W-1:0] cfg_data,
  bapr_in_if.sink                      in_ch,
  bapr_out_if.source                   out_ch
);
  import bapr_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + $clog2(BLOCK_LEN);
  localparam int NUM_W = SAMPLE_BITS + 8;
  localparam int CNT_W = $clog2(BLOCK_LEN + 1);
  localparam int EXT_W = ((NUM_W > PCT_W) ? NUM_W : PCT_W) + 1;

  localparam logic [NUM_W-1:0] ROUND_OFS = NUM_W'(BLOCK_LEN / 2);
  localparam logic [DVS_W-1:0] BLK_DVS   = DVS_W'(BLOCK_LEN);
  localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(BLOCK_LEN - 1);
  localparam logic [EXT_W-1:0] POS_LIM   = EXT_W'(PCT_MAX);
  localparam logic [EXT_W-1:0] NEG_LIM   = EXT_W'(PCT_MIN);

  bapr_state_t state, state_next;

  logic [RANGE_W-1:0]     range_q;
  logic [CNT_W-1:0]       sample_cnt;
  logic [SAMPLE_BITS-1:0] ref_avg;
  logic                   ref_valid;
  logic [SAMPLE_BITS-1:0] avg_q;
  logic signed [NUM_W:0]  num_q;
  logic [PCT_W-1:0]       pct_q;
  logic                   out_valid;

  acc_ctrl_t          acc_ctrl;
  logic               acc_busy;
  logic [SUM_W-1:0]   acc_sum;
  logic               div_start;
  logic               div_busy;
  logic [NUM_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic [NUM_W-1:0]   div_quot;

  logic               last_sample;
  logic               out_load;
  logic [RANGE_W-1:0] range_eff;
  logic signed [NUM_W:0] diff_x;
  logic signed [NUM_W:0] num;
  logic [NUM_W:0]     num_abs;
  logic [EXT_W-1:0]   qx;
  logic [EXT_W-1:0]   qx_neg;
  logic [PCT_W-1:0]   pct_val;

  bapr_serial_acc #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_acc (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (acc_ctrl),
    .sample (in_ch.sample),
    .busy   (acc_busy),
    .sum    (acc_sum)
  );

  bapr_serial_div #(
    .DVD_W (NUM_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  assign last_sample = (sample_cnt == LAST_CNT);
  assign range_eff   = (range_q == '0) ? RANGE_W'(1) : range_q;

  // Percent numerator: 200*(ref - avg) + range
  assign diff_x = $signed((NUM_W+1)'(ref_avg)) - $signed((NUM_W+1)'(avg_q));
  assign num    = (diff_x <<< 7) + (diff_x <<< 6) + (diff_x <<< 3)
                + $signed((NUM_W+1)'(range_eff));
  assign num_abs = num_q[NUM_W] ? (~num_q + 1'b1) : num_q;

  // Divider operands: block average first, then percent
  assign div_dvd = (state == ST_ACC) ? (NUM_W'(acc_sum) + ROUND_OFS) : num_abs[NUM_W-1:0];
  assign div_dvs = (state == ST_ACC) ? BLK_DVS : {range_eff, 1'b0};

  // Sign, truncation toward zero and saturation of the percent
  assign qx     = EXT_W'(div_quot);
  assign qx_neg = ~qx + 1'b1;
  always_comb begin
    if (!num_q[NUM_W]) begin
      pct_val = (qx > POS_LIM) ? PCT_MAX : qx[PCT_W-1:0];
    end else begin
      pct_val = (qx > NEG_LIM) ? PCT_MIN : qx_neg[PCT_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_ch.valid) state_next = ST_ACC;
      end
      ST_ACC: begin
        if (!acc_busy) state_next = last_sample ? ST_AVG : ST_IDLE;
      end
      ST_AVG: begin
        if (!div_busy) state_next = ref_valid ? ST_PREP : ST_IDLE;
      end
      ST_PREP: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_PCT;
      ST_PCT: begin
        if (!div_busy) state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid || out_ch.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ch.ready    = 1'b0;
    acc_ctrl.start = 1'b0;
    acc_ctrl.clear = 1'b0;
    div_start      = 1'b0;
    out_load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ch.ready    = 1'b1;
        acc_ctrl.start = in_ch.valid;
      end
      ST_ACC: begin
        acc_ctrl.clear = !acc_busy && last_sample;
        div_start      = !acc_busy && last_sample;
      end
      ST_LOAD: div_start = 1'b1;
      ST_PUSH: out_load  = !out_valid || out_ch.ready;
      ST_AVG, ST_PREP, ST_PCT: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      range_q    <= RANGE_RESET;
      sample_cnt <= '0;
      ref_avg    <= '0;
      ref_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) range_q <= cfg_data;
      if (state == ST_ACC && !acc_busy) begin
        sample_cnt <= last_sample ? '0 : sample_cnt + 1'b1;
      end
      if (state == ST_AVG && !div_busy && !ref_valid) begin
        ref_avg   <= div_quot[SAMPLE_BITS-1:0];
        ref_valid <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_AVG && !div_busy) avg_q <= div_quot[SAMPLE_BITS-1:0];
    if (state == ST_PREP) num_q <= num;
    if (state == ST_PCT && !div_busy) pct_q <= pct_val;
    if (out_load) begin
      out_ch.altitude_percent <= pct_q;
      out_ch.block_average    <= AVG_W'(avg_q);
    end
  end

  assign out_ch.valid = out_valid;

  // Reference, once taken, is kept until reset
  a_ref_kept: assert property (@(posedge clk) disable iff (rst)
    ref_valid |=> ref_valid)
    else $error("reference lost");

  // Divider only started when free
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // No result before a reference exists
  a_res_ref: assert property (@(posedge clk) disable iff (rst)
    out_load |-> ref_valid)
    else $error("result without reference");

endmodule

>>> rtl/bapr_serial_acc.sv
module bapr_serial_acc #(
  parameter int SAMPLE_BITS = bapr_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_W       = 17
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bapr_pkg::acc_ctrl_t    ctrl,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   busy,
  output logic [SUM_W-1:0]       sum
);
  import bapr_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(SUM_W - 1);

  logic [SUM_W-1:0] sum_sr;
  logic [SUM_W-1:0] addend;
  logic             carry;
  logic [CNT_W-1:0] bit_cnt;
  logic             sum_bit;
  logic             carry_next;

  // One-bit full adder, LSB first
  assign sum_bit    = sum_sr[0] ^ addend[0] ^ carry;
  assign carry_next = (sum_sr[0] & addend[0]) | (sum_sr[0] & carry) | (addend[0] & carry);

  // Sum rotates through itself; after SUM_W steps it is back in place
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
      sum_sr  <= '0;
    end else if (ctrl.clear) begin
      sum_sr <= '0;
    end else if (ctrl.start) begin
      addend  <= SUM_W'(sample);
      carry   <= 1'b0;
      bit_cnt <= '0;
      busy    <= 1'b1;
    end else if (busy) begin
      sum_sr  <= {sum_bit, sum_sr[SUM_W-1:1]};
      addend  <= {1'b0, addend[SUM_W-1:1]};
      carry   <= carry_next;
      bit_cnt <= bit_cnt + 1'b1;
      if (bit_cnt == LAST_BIT) begin
        busy <= 1'b0;
      end
    end
  end

  assign sum = sum_sr;

  // Pass must end exactly after the last bit
  a_pass_len: assert property (@(posedge clk) disable iff (rst)
    busy && bit_cnt == LAST_BIT && !ctrl.clear && !ctrl.start |=> !busy)
    else $error("accumulator pass length wrong");

endmodule

>>> rtl/bapr_serial_div.sv
module bapr_serial_div #(
  parameter int DVD_W = 20,
  parameter int DVS_W = bapr_pkg::DVS_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);
  import bapr_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] qsr;
  logic [CNT_W-1:0] step;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   trial_diff;
  logic             fits;

  // Restoring step: bring down one dividend bit, try the subtract
  assign trial      = {rem, qsr[DVD_W-1]};
  assign trial_diff = trial - {1'b0, dvs};
  assign fits       = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      rem  <= '0;
      dvs  <= divisor;
      qsr  <= dividend;
      step <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      rem  <= fits ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
      qsr  <= {qsr[DVD_W-2:0], fits};
      step <= step + 1'b1;
      if (step == LAST_STEP) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = qsr;

  // Partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < dvs)
    else $error("partial remainder out of range");

  // One quotient bit per step, DVD_W steps
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    busy && step == LAST_STEP && !start |=> !busy)
    else $error("division length wrong");

endmodule

>>> test/tb_block_average_relative_percent_top.sv
`timescale 1ns / 1ps

module tb_block_average_relative_percent_top;

  localparam int BLOCK_LEN   = bapr_pkg::BLOCK_LEN_DEF;
  localparam int SAMPLE_BITS = bapr_pkg::SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
  localparam int RANGE_MAX   = (1 << bapr_pkg::RANGE_W) - 1;
  localparam int PCT_HI      = (1 << (bapr_pkg::PCT_W - 1)) - 1;
  localparam int PCT_LO      = -(1 << (bapr_pkg::PCT_W - 1));

  // Quiet time before a range write (covers one sample add plus a block end)
  localparam int SETTLE_CYCLES = 150;
  localparam int DRAIN_CYCLES  = 200;

  localparam int SEGMENTS_PER_PHASE = 4;
  localparam int SAMPLES_PER_SEGMENT = 75;

  typedef struct packed {
    logic signed [bapr_pkg::PCT_W-1:0] percent;
    logic        [bapr_pkg::AVG_W-1:0] average;
  } reading_t;

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [bapr_pkg::RANGE_W-1:0] cfg_data;

  bapr_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  bapr_out_if                             out_ch ();

  block_average_relative_percent_top #(
    .BLOCK_LEN  (BLOCK_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  // Predictor state
  int                           blk_sum;
  int                           blk_count;
  logic [bapr_pkg::AVG_W-1:0]   ref_level;
  bit                           ref_set;
  logic [bapr_pkg::RANGE_W-1:0] range_reg;
  reading_t                     pending_readings[$];

  // Stimulus knobs
  int idle_pct;
  int stall_pct;
  int level;
  int spread;
  int fail_count;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Rounded-half-up mean of one block
  function automatic logic [bapr_pkg::AVG_W-1:0] rounded_mean(input int sum);
    int m;
    m = ((2 * sum + BLOCK_LEN) / 2) / BLOCK_LEN;
    return m[bapr_pkg::AVG_W-1:0];
  endfunction

  // Percent of (reference - average) over range; division truncates toward zero
  function automatic logic signed [bapr_pkg::PCT_W-1:0] relative_percent(
    input logic [bapr_pkg::AVG_W-1:0] avg
  );
    int r;
    int diff;
    int pct;
    r    = (range_reg == '0) ? 1 : int'(range_reg);
    diff = int'(ref_level) - int'(avg);
    pct  = (200 * diff + r) / (2 * r);
    if (pct > PCT_HI) pct = PCT_HI;
    if (pct < PCT_LO) pct = PCT_LO;
    return pct[bapr_pkg::PCT_W-1:0];
  endfunction

  // Fold one accepted sample into the block; queue a reading at block end
  function automatic void account_sample(input logic [SAMPLE_BITS-1:0] s);
    logic [bapr_pkg::AVG_W-1:0] avg;
    reading_t                   rd;
    blk_sum   += int'(s);
    blk_count += 1;
    if (blk_count == BLOCK_LEN) begin
      avg       = rounded_mean(blk_sum);
      blk_sum   = 0;
      blk_count = 0;
      if (!ref_set) begin
        // first block only sets the reference
        ref_level = avg;
        ref_set   = 1'b1;
      end else begin
        rd.percent = relative_percent(avg);
        rd.average = avg;
        pending_readings.push_back(rd);
      end
    end
  endfunction

  // Random sample: each block gets its own level and spread, plus rail hits
  function automatic logic [SAMPLE_BITS-1:0] draw_sample();
    int v;
    if (blk_count == 0) begin
      level = $urandom_range(0, SAMPLE_MAX);
      case ($urandom_range(0, 2))
        0:       spread = 0;
        1:       spread = 64;
        default: spread = SAMPLE_MAX;
      endcase
    end
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = SAMPLE_MAX;
      default: v = level + int'($urandom_range(0, 2 * spread)) - spread;
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Send one sample; entered and left at a falling edge
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    account_sample(s);
    @(negedge clk);
  endtask

  // Write range_counts once the block has gone quiet
  task automatic program_range(input logic [bapr_pkg::RANGE_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    range_reg  = v;
  endtask

  // Result receiver: ready toggles at random per stall setting
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected result: altitude_percent %0d block_average %0d",
               out_ch.altitude_percent, out_ch.block_average);
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        if (out_ch.altitude_percent !== want.percent) begin
          $error("altitude_percent: expected %0d, got %0d",
                 want.percent, out_ch.altitude_percent);
          fail_count++;
        end
        if (out_ch.block_average !== want.average) begin
          $error("block_average: expected %0d, got %0d",
                 want.average, out_ch.block_average);
          fail_count++;
        end
      end
    end
  end

  // Reference block: alternating rails, no result expected
  task automatic test_reference_block();
    for (int i = 0; i < BLOCK_LEN; i++) begin
      send_sample((i % 2 == 0) ? SAMPLE_MAX[SAMPLE_BITS-1:0] : '0);
    end
    in_ch.valid <= 1'b0;
  endtask

  // Full-scale blocks: all zeros at reset range, then all ones at range 1
  task automatic test_full_scale_blocks();
    for (int i = 0; i < BLOCK_LEN; i++) send_sample('0);
    program_range(1);
    for (int i = 0; i < BLOCK_LEN; i++) send_sample(SAMPLE_MAX[SAMPLE_BITS-1:0]);
    in_ch.valid <= 1'b0;
  endtask

  // Random samples under one idling setting, range changed per segment
  task automatic test_random_phase(input int phase);
    logic [bapr_pkg::RANGE_W-1:0] rng;
    case (phase)
      1:       begin idle_pct = 55; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 55; end
      3:       begin idle_pct = 30; stall_pct = 30; end
      default: begin idle_pct = 0;  stall_pct = 0;  end
    endcase
    for (int seg = 0; seg < SEGMENTS_PER_PHASE; seg++) begin
      if (seg == 0) begin
        // each phase opens on a corner of the range register (phase 3 on its reset value)
        case (phase)
          0:       rng = 1;
          1:       rng = RANGE_MAX[bapr_pkg::RANGE_W-1:0];
          2:       rng = '0;
          default: rng = bapr_pkg::RANGE_RESET;
        endcase
      end else begin
        case ($urandom_range(0, 4))
          0:       rng = 1;
          1:       rng = RANGE_MAX[bapr_pkg::RANGE_W-1:0];
          2:       rng = '0;
          default: rng = bapr_pkg::RANGE_W'($urandom_range(1, RANGE_MAX));
        endcase
      end
      program_range(rng);
      for (int i = 0; i < SAMPLES_PER_SEGMENT; i++) send_sample(draw_sample());
    end
    in_ch.valid <= 1'b0;
  endtask

  // Main sequence
  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    level        = 0;
    spread       = 0;
    fail_count   = 0;
    blk_sum      = 0;
    blk_count    = 0;
    ref_level    = '0;
    ref_set      = 1'b0;
    range_reg    = bapr_pkg::RANGE_RESET;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reference_block();
    @(negedge clk);
    test_full_scale_blocks();
    @(negedge clk);
    for (int p = 0; p < 4; p++) begin
      test_random_phase(p);
      @(negedge clk);
    end

    // drain outstanding readings, then let the block settle
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
